>>> rtl/core/sab_pkg.sv
`timescale 1ns / 1ps

package sab_pkg;

    // Text capacity and field widths
    localparam int MAX_LEN  = 1024;
    localparam int PW       = 10;           // position / rank width
    localparam int NW       = 11;           // length, index and count width
    localparam int KEY_SPAN = MAX_LEN + 257; // counting sort key range
    localparam int KW       = 11;           // counting sort key width

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    // Sub-step numbers within one element
    localparam logic [1:0] STEP_0 = 2'd0;
    localparam logic [1:0] STEP_1 = 2'd1;
    localparam logic [1:0] STEP_2 = 2'd2;
    localparam logic [1:0] STEP_3 = 2'd3;

    // Build phases
    typedef enum logic [7:0] {
        PH_IDLE = 8'b0000_0001,
        PH_INIT = 8'b0000_0010,
        PH_CLR  = 8'b0000_0100,
        PH_HIST = 8'b0000_1000,
        PH_PSUM = 8'b0001_0000,
        PH_SCAT = 8'b0010_0000,
        PH_RANK = 8'b0100_0000,
        PH_COPY = 8'b1000_0000
    } phase_t;

    // Controller to datapath
    typedef struct packed {
        phase_t     phase;
        logic [1:0] step;
        logic       pass_a;     // 0: sort by second key, 1: by first key
        logic       idx_inc;
        logic       idx_clr;
        logic       len_dbl;
        logic       set_built;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic go;               // load item with is_last accepted
        logic idx_last;         // index at end of current sweep
        logic finish;           // all ranks distinct or len covers text
    } stat_t;

endpackage

>>> rtl/core/suffix_array_builder.sv
`timescale 1ns / 1ps
// Load and read items: one accepted per cycle while idle; results are registered.
// A load with is_last starts the build; busy stays high through the counting
// sort sweeps over the 1281-entry count memory and the per-element steps of
// the shared memory ports.
// Reset (rst_n low, asynchronous) empties the text and clears the built flag.
// Results carry no backpressure: done marks each one for exactly one cycle.

module suffix_array_builder
    import sab_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          req_type,
    input  logic [7:0]    char_code,
    input  logic          is_last,
    input  logic [PW-1:0] rank_index,
    output logic          done,
    output logic [PW-1:0] position,
    output logic [1:0]    status
);

    cmd_t  cmd;
    stat_t stat;

    sab_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sab_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .start      (start),
        .req_type   (req_type),
        .char_code  (char_code),
        .is_last    (is_last),
        .rank_index (rank_index),
        .stat       (stat),
        .done       (done),
        .position   (position),
        .status     (status)
    );

    // Every result follows an accepted item
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without item");

    // Status never takes the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_RANGE || status == ST_OVF))
        else $error("bad status code");

endmodule

>>> rtl/core/sab_ctrl.sv
`timescale 1ns / 1ps

module sab_ctrl
    import sab_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    phase_t     state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic       pass_reg, pass_next;
    logic [1:0] last_step;
    logic       idx_inc, idx_clr, len_dbl, set_built;

    // Last sub-step per element in each phase
    always_comb
    begin
        case (state_reg)
            PH_INIT: last_step = STEP_1;
            PH_CLR:  last_step = STEP_0;
            PH_HIST: last_step = STEP_3;
            PH_PSUM: last_step = STEP_1;
            PH_SCAT: last_step = STEP_3;
            PH_RANK: last_step = STEP_2;
            PH_COPY: last_step = STEP_1;
            default: last_step = STEP_0;
        endcase
    end

    // Phase sequencing
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pass_next  = pass_reg;
        idx_inc    = 1'b0;
        idx_clr    = 1'b0;
        len_dbl    = 1'b0;
        set_built  = 1'b0;
        if (state_reg == PH_IDLE)
        begin
            step_next = STEP_0;
            if (stat.go)
            begin
                state_next = PH_INIT;
                pass_next  = 1'b0;
                idx_clr    = 1'b1;
            end
        end
        else if (step_reg != last_step)
        begin
            step_next = step_reg + 2'd1;
        end
        else
        begin
            step_next = STEP_0;
            if (!stat.idx_last)
            begin
                idx_inc = 1'b1;
            end
            else
            begin
                idx_clr = 1'b1;
                case (state_reg)
                    PH_INIT: state_next = PH_CLR;
                    PH_CLR:  state_next = PH_HIST;
                    PH_HIST: state_next = PH_PSUM;
                    PH_PSUM: state_next = PH_SCAT;
                    PH_SCAT:
                    begin
                        if (pass_reg)
                        begin
                            state_next = PH_RANK;
                        end
                        else
                        begin
                            pass_next  = 1'b1;
                            state_next = PH_CLR;
                        end
                    end
                    PH_RANK: state_next = PH_COPY;
                    PH_COPY:
                    begin
                        if (stat.finish)
                        begin
                            set_built  = 1'b1;
                            state_next = PH_IDLE;
                        end
                        else
                        begin
                            len_dbl    = 1'b1;
                            pass_next  = 1'b0;
                            state_next = PH_CLR;
                        end
                    end
                    default: state_next = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_IDLE;
            step_reg  <= STEP_0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pass_reg  <= pass_next;
        end
    end

    assign cmd.phase     = state_reg;
    assign cmd.step      = step_reg;
    assign cmd.pass_a    = pass_reg;
    assign cmd.idx_inc   = idx_inc;
    assign cmd.idx_clr   = idx_clr;
    assign cmd.len_dbl   = len_dbl;
    assign cmd.set_built = set_built;
    assign busy          = (state_reg != PH_IDLE);

    // Step counter never passes the last step of its phase
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= last_step)
        else $error("step beyond phase end");

    // A build request leaves idle at once
    a_go_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_IDLE && stat.go) |=> (state_reg == PH_INIT))
        else $error("build did not start");

endmodule

>>> rtl/core/sab_dp.sv
`timescale 1ns / 1ps

module sab_dp
    import sab_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          cmd,
    input  logic          start,
    input  logic          req_type,
    input  logic [7:0]    char_code,
    input  logic          is_last,
    input  logic [PW-1:0] rank_index,
    output stat_t         stat,
    output logic          done,
    output logic [PW-1:0] position,
    output logic [1:0]    status
);

    // Storage
    logic [7:0]    text_mem    [MAX_LEN];
    logic [PW-1:0] rank_mem    [MAX_LEN];
    logic [PW-1:0] order_mem   [MAX_LEN];
    logic [PW-1:0] scratch_mem [MAX_LEN];
    logic [PW-1:0] fresh_mem   [MAX_LEN];
    logic [NW-1:0] count_mem   [KEY_SPAN];

    logic [7:0]    text_q;
    logic [PW-1:0] rank_a_q, rank_b_q, order_q, scratch_q, fresh_q;
    logic [NW-1:0] cnt_q;

    // Control registers
    logic [NW-1:0] idx_reg, n_reg, len_reg;
    logic          built_reg;
    logic          s1_v_reg, s1_read_reg, s1_ok_reg, s1_ovf_reg;
    logic          done_reg;

    // Work registers
    logic [PW-1:0] p_reg, fr_reg, prev_ka_reg;
    logic [KW-1:0] key_reg, prev_kb_reg;
    logic [NW-1:0] sum_reg;
    logic [PW-1:0] position_reg;
    logic [1:0]    status_reg;

    logic          idle, accept, load_acc, read_acc, store_ok, go;
    logic          ph_init, ph_clr, ph_hist, ph_psum, ph_scat, ph_rank, ph_copy;
    logic          st1, st2, st3;
    logic [PW-1:0] pos_sel, rank_b_addr;
    logic [NW-1:0] n_minus_p;
    logic [KW-1:0] kb_calc, key_calc;
    logic          differs;
    logic [PW-1:0] fr_calc;

    assign idle     = (cmd.phase == PH_IDLE);
    assign accept   = start & idle;
    assign load_acc = accept & (req_type == REQ_LOAD);
    assign read_acc = accept & (req_type == REQ_READ);
    assign store_ok = built_reg | (n_reg < NW'(MAX_LEN));
    assign go       = load_acc & is_last;

    assign ph_init = (cmd.phase == PH_INIT);
    assign ph_clr  = (cmd.phase == PH_CLR);
    assign ph_hist = (cmd.phase == PH_HIST);
    assign ph_psum = (cmd.phase == PH_PSUM);
    assign ph_scat = (cmd.phase == PH_SCAT);
    assign ph_rank = (cmd.phase == PH_RANK);
    assign ph_copy = (cmd.phase == PH_COPY);
    assign st1 = (cmd.step == STEP_1);
    assign st2 = (cmd.step == STEP_2);
    assign st3 = (cmd.step == STEP_3);

    // Position whose keys are fetched this element
    always_comb
    begin
        if (ph_rank)
            pos_sel = scratch_q;
        else if (cmd.pass_a)
            pos_sel = order_q;
        else
            pos_sel = idx_reg[PW-1:0];
    end
    assign rank_b_addr = pos_sel + len_reg[PW-1:0];

    // Second key: rank at p+len plus one, zero past the end
    assign n_minus_p = n_reg - {1'b0, p_reg};
    assign kb_calc   = (len_reg < n_minus_p) ? ({1'b0, rank_b_q} + KW'(1)) : '0;
    assign key_calc  = cmd.pass_a ? {1'b0, rank_a_q} : kb_calc;

    // Dense rank of the next sorted position
    assign differs = (rank_a_q != prev_ka_reg) || (kb_calc != prev_kb_reg);
    assign fr_calc = (idx_reg == '0) ? '0 : (fr_reg + PW'(differs));

    // Text memory
    always_ff @(posedge clk)
    begin
        if (load_acc && store_ok)
            text_mem[built_reg ? '0 : n_reg[PW-1:0]] <= char_code;
        text_q <= text_mem[idx_reg[PW-1:0]];
    end

    // Rank memory, two read ports
    always_ff @(posedge clk)
    begin
        if (ph_init && st1)
            rank_mem[idx_reg[PW-1:0]] <= {{(PW-8){1'b0}}, text_q};
        else if (ph_copy && st1)
            rank_mem[idx_reg[PW-1:0]] <= fresh_q;
        rank_a_q <= rank_mem[pos_sel];
        rank_b_q <= rank_mem[rank_b_addr];
    end

    // Order memory: first sort pass result, then final order
    always_ff @(posedge clk)
    begin
        if (ph_scat && !cmd.pass_a && st3)
            order_mem[cnt_q[PW-1:0]] <= p_reg;
        else if (ph_rank && st1)
            order_mem[idx_reg[PW-1:0]] <= scratch_q;
        order_q <= order_mem[idle ? rank_index : idx_reg[PW-1:0]];
    end

    // Scratch memory: second sort pass result
    always_ff @(posedge clk)
    begin
        if (ph_scat && cmd.pass_a && st3)
            scratch_mem[cnt_q[PW-1:0]] <= p_reg;
        scratch_q <= scratch_mem[idx_reg[PW-1:0]];
    end

    // Fresh rank memory
    always_ff @(posedge clk)
    begin
        if (ph_rank && st2)
            fresh_mem[p_reg] <= fr_calc;
        fresh_q <= fresh_mem[idx_reg[PW-1:0]];
    end

    // Count memory: clear, histogram, prefix sum, scatter
    always_ff @(posedge clk)
    begin
        if (ph_clr)
            count_mem[idx_reg] <= '0;
        else if ((ph_hist || ph_scat) && st3)
            count_mem[key_reg] <= cnt_q + NW'(1);
        else if (ph_psum && st1)
            count_mem[idx_reg] <= sum_reg;
        cnt_q <= count_mem[ph_psum ? idx_reg : key_calc];
    end

    // Work registers
    always_ff @(posedge clk)
    begin
        if ((ph_hist || ph_scat || ph_rank) && st1)
            p_reg <= pos_sel;
        if ((ph_hist || ph_scat) && st2)
            key_reg <= key_calc;
        if (ph_rank && st2)
        begin
            fr_reg      <= fr_calc;
            prev_ka_reg <= rank_a_q;
            prev_kb_reg <= kb_calc;
        end
        if (!ph_psum)
            sum_reg <= '0;
        else if (st1)
            sum_reg <= sum_reg + cnt_q;
    end

    // Control registers: index, length, doubling span, built flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            n_reg     <= '0;
            len_reg   <= NW'(1);
            built_reg <= 1'b0;
        end
        else
        begin
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + NW'(1);
            if (load_acc)
            begin
                if (built_reg)
                    n_reg <= NW'(1);
                else if (store_ok)
                    n_reg <= n_reg + NW'(1);
            end
            if (go)
                len_reg <= NW'(1);
            else if (cmd.len_dbl)
                len_reg <= {len_reg[NW-2:0], 1'b0};
            if (load_acc)
                built_reg <= 1'b0;
            else if (cmd.set_built)
                built_reg <= 1'b1;
        end
    end

    // Result pipeline: stage one waits for the order read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            done_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_read_reg <= read_acc;
        s1_ok_reg   <= built_reg && ({1'b0, rank_index} < n_reg);
        s1_ovf_reg  <= !store_ok;
        if (s1_read_reg)
        begin
            position_reg <= s1_ok_reg ? order_q : '0;
            status_reg   <= s1_ok_reg ? ST_OK : ST_RANGE;
        end
        else
        begin
            position_reg <= '0;
            status_reg   <= s1_ovf_reg ? ST_OVF : ST_OK;
        end
    end

    // Status to controller
    assign stat.go       = go;
    assign stat.idx_last = (ph_clr || ph_psum) ? (idx_reg == NW'(KEY_SPAN - 1))
                                               : (idx_reg == n_reg - NW'(1));
    assign stat.finish   = ({1'b0, fr_reg} == n_reg - NW'(1)) || (len_reg >= n_reg);

    assign done     = done_reg;
    assign position = position_reg;
    assign status   = status_reg;

    // Non-ok results carry position zero
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (position == '0))
        else $error("position set on failed item");

    // Text length never passes capacity
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= NW'(MAX_LEN))
        else $error("text length over capacity");

endmodule

>>> sim/sab_checker.sv
`timescale 1ns / 1ps

module sab_checker
    import sab_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  logic          req_type,
    input  logic [7:0]    char_code,
    input  logic          is_last,
    input  logic [PW-1:0] rank_index,
    input  logic          done,
    input  logic [PW-1:0] position,
    input  logic [1:0]    status,
    output int            errors,
    output int            outstanding
);

    typedef struct packed {
        logic [PW-1:0] position;
        logic [1:0]    status;
    } answer_t;

    // Shadow copy of the text and the sorted suffix order
    logic [7:0]  text_copy [MAX_LEN];
    int unsigned rank_cur  [MAX_LEN];
    int unsigned sorted_pos[MAX_LEN];
    int unsigned first_key [MAX_LEN];
    int unsigned second_key[MAX_LEN];
    int unsigned work_pos  [MAX_LEN];
    int unsigned next_rank [MAX_LEN];
    int unsigned bucket    [KEY_SPAN];
    int unsigned text_len;
    bit          is_built;

    answer_t answer_q[$];

    assign outstanding = answer_q.size();

    // Stable counting sort of positions in src by key, into dst
    function automatic void bucket_sort(input bit by_first, input bit src_is_work);
        int unsigned k;
        int unsigned sum;
        int unsigned c;
        int unsigned p;
        int unsigned key;
        for (k = 0; k < KEY_SPAN; k++)
            bucket[k] = 0;
        for (k = 0; k < text_len; k++)
        begin
            p = src_is_work ? work_pos[k] : sorted_pos[k];
            key = by_first ? first_key[p] : second_key[p];
            bucket[key]++;
        end
        sum = 0;
        for (k = 0; k < KEY_SPAN; k++)
        begin
            c = bucket[k];
            bucket[k] = sum;
            sum += c;
        end
        for (k = 0; k < text_len; k++)
        begin
            p = src_is_work ? work_pos[k] : sorted_pos[k];
            key = by_first ? first_key[p] : second_key[p];
            if (src_is_work)
                sorted_pos[bucket[key]] = p;
            else
                work_pos[bucket[key]] = p;
            bucket[key]++;
        end
    endfunction

    // Prefix doubling over the current text
    function automatic void build_order();
        int unsigned n;
        int unsigned i;
        int unsigned span;
        int unsigned p;
        int unsigned c;
        n = text_len;
        span = 1;
        is_built = 1'b1;
        if (n == 0)
            return;
        for (i = 0; i < n; i++)
            rank_cur[i] = text_copy[i];
        forever
        begin
            for (i = 0; i < n; i++)
            begin
                first_key[i] = rank_cur[i];
                // past the end sorts lowest
                second_key[i] = (span < n - i) ? rank_cur[i + span] + 1 : 0;
                work_pos[i] = i;
            end
            bucket_sort(1'b0, 1'b1);
            bucket_sort(1'b1, 1'b0);
            for (i = 0; i < n; i++)
                sorted_pos[i] = work_pos[i];
            next_rank[sorted_pos[0]] = 0;
            for (i = 1; i < n; i++)
            begin
                p = sorted_pos[i - 1];
                c = sorted_pos[i];
                next_rank[c] = next_rank[p] +
                    ((first_key[p] != first_key[c] || second_key[p] != second_key[c]) ? 1 : 0);
            end
            for (i = 0; i < n; i++)
                rank_cur[i] = next_rank[i];
            if (rank_cur[sorted_pos[n - 1]] == n - 1 || span >= n)
                break;
            span *= 2;
        end
    endfunction

    // Predict on accepted items, compare on strobed results
    always @(posedge clk or negedge rst_n)
    begin
        answer_t ans;
        answer_t want;
        if (!rst_n)
        begin
            text_len = 0;
            is_built = 1'b0;
            errors   <= 0;
            answer_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (answer_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result with nothing pending: position=%0d status=%0d",
                                 $realtime, position, status);
                    errors <= errors + 1;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (want.position !== position || want.status !== status)
                    begin
                        if (errors < 10)
                            $display({"%0t: mismatch: expected position=%0d status=%0d, ",
                                      "got position=%0d status=%0d"},
                                     $realtime, want.position, want.status,
                                     position, status);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                ans.position = '0;
                ans.status   = ST_OK;
                if (req_type == REQ_LOAD)
                begin
                    if (is_built)
                    begin
                        is_built = 1'b0;
                        text_len = 0;
                    end
                    if (text_len < MAX_LEN)
                    begin
                        text_copy[text_len] = char_code;
                        text_len++;
                    end
                    else
                        ans.status = ST_OVF;
                    if (is_last)
                        build_order();
                end
                else
                begin
                    if (is_built && rank_index < text_len)
                        ans.position = sorted_pos[rank_index][PW-1:0];
                    else
                        ans.status = ST_RANGE;
                end
                answer_q.insert(answer_q.size(), ans);
            end
        end
    end

endmodule

>>> sim/tb_suffix_array_builder.sv
`timescale 1ns / 1ps

module tb_suffix_array_builder;
    import sab_pkg::*;

    localparam int STALL_LIMIT = 2_000_000;
    localparam int TOTAL_ITEMS = 1250;
    localparam int BULK_ITEMS  = MAX_LEN + 70;   // full text with overflow and its reads

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic          req_type;
    logic [7:0]    char_code;
    logic          is_last;
    logic [PW-1:0] rank_index;
    logic          done;
    logic [PW-1:0] position;
    logic [1:0]    status;
    int            errors;
    int            outstanding;

    int sent_items;
    int idle_pct;
    int stall_cycles;

    suffix_array_builder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .char_code  (char_code),
        .is_last    (is_last),
        .rank_index (rank_index),
        .done       (done),
        .position   (position),
        .status     (status)
    );

    sab_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .char_code  (char_code),
        .is_last    (is_last),
        .rank_index (rank_index),
        .done       (done),
        .position   (position),
        .status     (status),
        .errors     (errors),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: cycles with no item accepted and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_suffix_array_builder: FAIL");
                $finish;
            end
        end
    end

    // Drive one item, with idle cycles per the run phase, and wait until it is taken
    task automatic send_item(input logic rt, input logic [7:0] ch, input logic lst,
                             input logic [PW-1:0] idx);
        @(negedge clk);
        if (sent_items < TOTAL_ITEMS / 3)
            idle_pct = 35;
        else if (sent_items < 2 * TOTAL_ITEMS / 3)
            idle_pct = 46;
        else
            idle_pct = 0;
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start      = 1'b1;
        req_type   = rt;
        char_code  = ch;
        is_last    = lst;
        rank_index = idx;
        do
            @(posedge clk);
        while (busy);
        sent_items++;
    endtask

    task automatic load_char(input logic [7:0] ch, input logic lst);
        send_item(REQ_LOAD, ch, lst, PW'($urandom));
    endtask

    task automatic read_rank(input logic [PW-1:0] idx);
        send_item(REQ_READ, 8'($urandom), 1'($urandom), idx);
    endtask

    function automatic logic [7:0] pick_char(input int mode, input logic [7:0] fixed_ch);
        case (mode)
            0: return 8'($urandom);
            1: return $urandom_range(1) ? 8'hFF : 8'h00;
            2: return 8'h61 + 8'($urandom_range(2));
            default: return fixed_ch;
        endcase
    endfunction

    // One text: loads with the final one marked and stray reads among them, then reads
    task automatic run_text(input int n_chars, input int n_reads);
        int mode;
        int i;
        int cap;
        logic [7:0] fixed_ch;
        mode = $urandom_range(3);
        fixed_ch = 8'($urandom);
        cap = (n_chars > MAX_LEN) ? MAX_LEN : n_chars;
        for (i = 0; i < n_chars; i++)
        begin
            // stray reads while the text is still open
            if ($urandom_range(99) < 4)
                read_rank(PW'($urandom));
            load_char(pick_char(mode, fixed_ch), i == n_chars - 1);
        end
        for (i = 0; i < n_reads; i++)
        begin
            if ($urandom_range(99) < 85)
                read_rank(PW'($urandom_range(cap < MAX_LEN ? cap : MAX_LEN - 1)));
            else
                read_rank(PW'($urandom));
        end
    endtask

    initial
    begin
        int k;
        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = REQ_LOAD;
        char_code  = '0;
        is_last    = 1'b0;
        rank_index = '0;
        sent_items = 0;
        idle_pct   = 35;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reads before anything is built
        read_rank('0);
        read_rank('1);
        // Short text with extreme characters
        load_char(8'hFF, 1'b0);
        load_char(8'h00, 1'b0);
        load_char(8'hFF, 1'b0);
        load_char(8'h00, 1'b1);
        for (k = 0; k <= 4; k++)
            read_rank(PW'(k));
        read_rank('1);
        // Single character text, then a new text after the build
        load_char(8'h41, 1'b1);
        read_rank(PW'(0));
        read_rank(PW'(1));
        load_char(8'h7A, 1'b0);
        read_rank(PW'(0));
        load_char(8'h7A, 1'b0);
        load_char(8'h7A, 1'b1);
        for (k = 0; k < 3; k++)
            read_rank(PW'(k));

        // Random texts across the idling phases
        while (sent_items < TOTAL_ITEMS - BULK_ITEMS)
            run_text($urandom_range(1, 40), $urandom_range(5, 30));

        // Full text with overflow; last marked item is itself dropped
        run_text(MAX_LEN + 6, 20);
        read_rank('1);
        read_rank(PW'(MAX_LEN - 2));

        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_suffix_array_builder: PASS");
        else
            $display("tb_suffix_array_builder: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/sab_pkg.sv
rtl/core/sab_ctrl.sv
rtl/core/sab_dp.sv
rtl/core/suffix_array_builder.sv
sim/sab_checker.sv
sim/tb_suffix_array_builder.sv
